// ===== rtl/core/rlepsd_pkg.sv =====
`timescale 1ns / 1ps

package rlepsd_pkg;

  // Default width of the pixel position counter.
  localparam int PIXEL_COUNT_BITS_DEF = 24;

  // Configuration port geometry: seven 32-bit registers at byte addresses 4*i.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int PPI_W = 24;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FORMAT_MODE      = 3'd0,
    REG_PIXELS_PER_IMAGE = 3'd1,
    REG_RAW_BYTE_CODE    = 3'd2,
    REG_RAW_WORD_CODE    = 3'd3,
    REG_RUN_BYTE_CODE    = 3'd4,
    REG_RUN_WORD_CODE    = 3'd5,
    REG_SHORT_RUN_BASE   = 3'd6
  } reg_idx_t;

  // Stream formats.
  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_WRUN = 2'd1,
    MODE_BRUN = 2'd2,
    MODE_HDR  = 2'd3
  } fmt_mode_t;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HEAD     = 4'd0,
    PH_CNT1_RUN = 4'd1,
    PH_CNT1_LIT = 4'd2,
    PH_CLO_RUN  = 4'd3,
    PH_CHI_RUN  = 4'd4,
    PH_CLO_LIT  = 4'd5,
    PH_CHI_LIT  = 4'd6,
    PH_COL_LO   = 4'd7,
    PH_COL_HI   = 4'd8,
    PH_LIT_LO   = 4'd9,
    PH_LIT_HI   = 4'd10
  } phase_t;

  typedef struct packed {
    fmt_mode_t        format_mode;
    logic [PPI_W-1:0] pixels_per_image;
    logic [7:0]       raw_byte_code;
    logic [7:0]       raw_word_code;
    logic [7:0]       run_byte_code;
    logic [7:0]       run_word_code;
    logic [7:0]       short_run_base;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [15:0] run_length;
    logic        image_done;
  } res_t;

  typedef struct packed {
    logic at_head;
    logic img_start;
  } prs_stat_t;

endpackage

// ===== rtl/core/rlepsd_cfg.sv =====
`timescale 1ns / 1ps

module rlepsd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rlepsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rlepsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rlepsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  output rlepsd_pkg::cfg_t                   cfg
);
  import rlepsd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_mode      <= MODE_RAW;
      cfg_r.pixels_per_image <= PPI_W'(1024);
      cfg_r.raw_byte_code    <= 8'd252;
      cfg_r.raw_word_code    <= 8'd253;
      cfg_r.run_byte_code    <= 8'd254;
      cfg_r.run_word_code    <= 8'd255;
      cfg_r.short_run_base   <= 8'd127;
    end else if (wr_en) begin
      unique case (idx)
        REG_FORMAT_MODE:      cfg_r.format_mode      <= fmt_mode_t'(pwdata[1:0]);
        REG_PIXELS_PER_IMAGE: cfg_r.pixels_per_image <= pwdata[PPI_W-1:0];
        REG_RAW_BYTE_CODE:    cfg_r.raw_byte_code    <= pwdata[7:0];
        REG_RAW_WORD_CODE:    cfg_r.raw_word_code    <= pwdata[7:0];
        REG_RUN_BYTE_CODE:    cfg_r.run_byte_code    <= pwdata[7:0];
        REG_RUN_WORD_CODE:    cfg_r.run_word_code    <= pwdata[7:0];
        REG_SHORT_RUN_BASE:   cfg_r.short_run_base   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT_MODE:      prdata = CFG_DATA_W'(cfg_r.format_mode);
      REG_PIXELS_PER_IMAGE: prdata = CFG_DATA_W'(cfg_r.pixels_per_image);
      REG_RAW_BYTE_CODE:    prdata = CFG_DATA_W'(cfg_r.raw_byte_code);
      REG_RAW_WORD_CODE:    prdata = CFG_DATA_W'(cfg_r.raw_word_code);
      REG_RUN_BYTE_CODE:    prdata = CFG_DATA_W'(cfg_r.run_byte_code);
      REG_RUN_WORD_CODE:    prdata = CFG_DATA_W'(cfg_r.run_word_code);
      REG_SHORT_RUN_BASE:   prdata = CFG_DATA_W'(cfg_r.short_run_base);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/rlepsd_parser.sv =====
`timescale 1ns / 1ps

module rlepsd_parser #(
  parameter int PIXEL_COUNT_BITS = rlepsd_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [7:0]            stream_byte,
  input  rlepsd_pkg::cfg_t      cfg,
  output logic                  res_vld,
  output rlepsd_pkg::res_t      res,
  output rlepsd_pkg::prs_stat_t stat
);
  import rlepsd_pkg::*;

  localparam int PCB = PIXEL_COUNT_BITS;
  localparam int SW  = (PCB > PPI_W) ? PCB : PPI_W;
  localparam int CW  = (PCB > 16) ? PCB : 16;

  phase_t          phase_r, phase_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic [7:0]      lowb_r, lowb_nxt;
  logic [15:0]     lit_r, lit_nxt;
  logic [PCB-1:0]  emitted_r, emitted_nxt;

  logic [SW-1:0]   size_ext;
  logic [PCB-1:0]  size;
  logic [PCB-1:0]  left;
  logic [CW-1:0]   left_w;
  logic [15:0]     len;
  logic [15:0]     cnt_hi;
  logic [15:0]     lit_dec;
  logic            do_head;
  logic            lit_start;
  logic [15:0]     lit_n;

  // Smaller of a 16-bit count and the pixels left in the image.
  function automatic logic [15:0] clip16(input logic [15:0] n, input logic [CW-1:0] lim);
    logic [CW-1:0] nw;
    nw = CW'(n);
    return (nw < lim) ? n : lim[15:0];
  endfunction

  // Pixels left; an image already full or of size zero still takes one pixel.
  assign size_ext = SW'(cfg.pixels_per_image);
  assign size     = size_ext[PCB-1:0];
  assign left     = (emitted_r >= size) ? PCB'(1) : size - emitted_r;
  assign left_w   = CW'(left);
  assign cnt_hi   = {stream_byte, cnt_r[7:0]};
  assign lit_dec  = lit_r - 16'd1;

  // Result of the current byte.
  always_comb begin
    res_vld = 1'b0;
    len     = 16'd1;
    unique case (phase_r)
      PH_COL_HI: begin
        res_vld = (cnt_r != 16'd0);
        len     = clip16(cnt_r, left_w);
      end
      PH_LIT_HI: begin
        res_vld = 1'b1;
      end
      default: ;
    endcase
    res.pixel_value = {stream_byte, lowb_r};
    res.run_length  = len;
    res.image_done  = (CW'(len) >= left_w);
  end

  // Next parser state.
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    lowb_nxt    = lowb_r;
    lit_nxt     = lit_r;
    emitted_nxt = emitted_r;
    do_head     = 1'b0;
    lit_start   = 1'b0;
    lit_n       = 16'd0;

    unique case (phase_r)
      PH_HEAD: do_head = 1'b1;
      PH_CNT1_RUN: begin
        cnt_nxt   = 16'(stream_byte);
        phase_nxt = PH_COL_LO;
      end
      PH_CNT1_LIT: begin
        lit_start = 1'b1;
        lit_n     = 16'(stream_byte);
      end
      PH_CLO_RUN: begin
        cnt_nxt   = 16'(stream_byte);
        phase_nxt = PH_CHI_RUN;
      end
      PH_CHI_RUN: begin
        cnt_nxt   = cnt_hi;
        phase_nxt = PH_COL_LO;
      end
      PH_CLO_LIT: begin
        cnt_nxt   = 16'(stream_byte);
        phase_nxt = PH_CHI_LIT;
      end
      PH_CHI_LIT: begin
        cnt_nxt   = cnt_hi;
        lit_start = 1'b1;
        lit_n     = cnt_hi;
      end
      PH_COL_LO: begin
        lowb_nxt  = stream_byte;
        phase_nxt = PH_COL_HI;
      end
      PH_COL_HI: phase_nxt = PH_HEAD;
      PH_LIT_LO: begin
        lowb_nxt  = stream_byte;
        phase_nxt = PH_LIT_HI;
      end
      PH_LIT_HI: begin
        lit_nxt   = lit_dec;
        phase_nxt = (lit_dec == 16'd0) ? PH_HEAD : PH_LIT_LO;
      end
      default: do_head = 1'b1;
    endcase

    if (do_head) begin
      unique case (cfg.format_mode)
        MODE_RAW: begin
          lowb_nxt  = stream_byte;
          lit_nxt   = 16'd1;
          phase_nxt = PH_LIT_HI;
        end
        MODE_WRUN: begin
          cnt_nxt   = 16'(stream_byte);
          phase_nxt = PH_CHI_RUN;
        end
        MODE_BRUN: begin
          cnt_nxt   = 16'(stream_byte);
          phase_nxt = PH_COL_LO;
        end
        MODE_HDR: begin
          if (stream_byte == cfg.raw_byte_code) begin
            phase_nxt = PH_CNT1_LIT;
          end else if (stream_byte == cfg.raw_word_code) begin
            phase_nxt = PH_CLO_LIT;
          end else if (stream_byte == cfg.run_byte_code) begin
            phase_nxt = PH_CNT1_RUN;
          end else if (stream_byte == cfg.run_word_code) begin
            phase_nxt = PH_CLO_RUN;
          end else if (stream_byte > cfg.short_run_base) begin
            cnt_nxt   = 16'(stream_byte - cfg.short_run_base);
            phase_nxt = PH_COL_LO;
          end else begin
            lit_start = 1'b1;
            lit_n     = 16'(stream_byte);
          end
        end
      endcase
    end

    // An empty literal block goes straight back to the header.
    if (lit_start) begin
      if (lit_n == 16'd0) begin
        phase_nxt = PH_HEAD;
      end else begin
        lit_nxt   = clip16(lit_n, left_w);
        phase_nxt = PH_LIT_LO;
      end
    end

    // The run that fills the image returns the parser to its reset state.
    if (res_vld) begin
      if (res.image_done) begin
        phase_nxt   = PH_HEAD;
        cnt_nxt     = 16'd0;
        lowb_nxt    = 8'd0;
        lit_nxt     = 16'd0;
        emitted_nxt = '0;
      end else begin
        emitted_nxt = emitted_r + PCB'(len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD;
      cnt_r     <= 16'd0;
      lowb_r    <= 8'd0;
      lit_r     <= 16'd0;
      emitted_r <= '0;
    end else if (go) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      lowb_r    <= lowb_nxt;
      lit_r     <= lit_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  assign stat.at_head   = (phase_r == PH_HEAD);
  assign stat.img_start = (emitted_r == '0);

endmodule

// ===== rtl/core/rle_pixel_stream_decoder_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Beat contents
// in_       input      in_valid / in_stall   in_stream_byte: one compressed stream byte
// out_      output     out_valid / out_stall out_pixel_value, out_run_length, out_image_done
// APB       config     psel/penable/pready   seven 32-bit registers at paddr 4*i
//
// The decoder takes one stream byte per cycle while in_stall is low. A byte accepted into
// the input byte register is parsed into the output run register once that register is
// free, so an output stall can hold it there; the parser state and the run are both
// updated together, which sets the rate of one byte per clock while the output does not stall.
// Reset is synchronous on rst_n low; it clears the parser and loads register defaults.
// A stall on the output holds the run register and the byte register, and in_stall
// rises only while both are full, so no beat is dropped or repeated.

module rle_pixel_stream_decoder_top #(
  parameter int PIXEL_COUNT_BITS = rlepsd_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_stream_byte,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        out_pixel_value,
  output logic [15:0]                        out_run_length,
  output logic                               out_image_done,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rlepsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rlepsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rlepsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready
);
  import rlepsd_pkg::*;

  cfg_t      cfg;
  res_t      res;
  prs_stat_t stat;
  logic      res_vld;

  // Input byte register.
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // Output run register.
  logic       out_v_r;
  res_t       out_r;

  logic       out_free;
  logic       go;

  // The output register can take a run when it is empty or being emptied now.
  assign out_free = !out_v_r || !out_stall;
  assign go       = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;

  rlepsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlepsd_parser #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .stream_byte (in_byte_r),
    .cfg         (cfg),
    .res_vld     (res_vld),
    .res         (res),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go && res_vld) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_pixel_value = out_r.pixel_value;
  assign out_run_length  = out_r.run_length;
  assign out_image_done  = out_r.image_done;

  // A parsed run always lands in the output register with a nonzero length.
  a_run_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_vld) |=> (out_valid && (out_run_length != 16'd0)))
    else $error("run register loaded without a nonzero run");

  // The input side only stalls while a byte waits behind a stalled run.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("input stalled without a full pipeline");

  // Finishing an image returns the parser to the header phase at pixel zero.
  a_image_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_vld && res.image_done) |=> (stat.at_head && stat.img_start))
    else $error("parser did not restart after the last run of an image");

endmodule
